// ===== design/sbca_pkg.sv =====
// sbca_pkg: types and constants shared by the sprite blitter modules
// no dependencies; imported by every design and checker file
package sbca_pkg;

  localparam int SX_W      = 10;
  localparam int SY_W      = 9;
  localparam int FX_W      = SX_W + 1;
  localparam int FY_W      = SY_W + 1;
  localparam int PIX_W     = 16;
  localparam int ADDR_W    = 19;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [PIX_W-1:0] ALPHA_MASK = 16'hF000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd3;

  typedef struct packed {
    logic             start_req;
    logic [PIX_W-1:0] pixel;
  } sbca_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [PIX_W-1:0]  write_pixel;
  } sbca_out_t;

  // classified draw job between front and back
  typedef struct packed {
    logic [FX_W-1:0]  fx;
    logic [FY_W-1:0]  fy;
    logic [PIX_W-1:0] pixel;
  } sbca_job_t;

endpackage

// ===== design/sbca_front.sv =====
// sbca_front: configuration registers, row/column counters and draw decision
// depends on sbca_pkg; pushes draw jobs into sbca_queue
module sbca_front #(
  parameter int FRAME_W = 640,
  parameter int FRAME_H = 480
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sbca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbca_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           in_push,
  output logic                           in_full,
  input  sbca_pkg::sbca_in_t             in_data,
  output logic                           q_push,
  input  logic                           q_full,
  output sbca_pkg::sbca_job_t            q_data
);
  import sbca_pkg::*;

  logic [SX_W-1:0] sprite_x_r;
  logic [SY_W-1:0] sprite_y_r;
  logic [SX_W-1:0] sprite_width_r;
  logic [SY_W-1:0] sprite_height_r;
  logic [SX_W-1:0] col_r, col_nxt, col_cur;
  logic [SY_W-1:0] row_r, row_nxt, row_cur;
  logic [FX_W-1:0] fx, col_inc;
  logic [FY_W-1:0] fy, row_inc;
  logic            draw;
  logic            accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sprite_x_r      <= '0;
      sprite_y_r      <= '0;
      sprite_width_r  <= '0;
      sprite_height_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SPRITE_X:      sprite_x_r      <= cfg_data[SX_W-1:0];
        CFG_SPRITE_Y:      sprite_y_r      <= cfg_data[SY_W-1:0];
        CFG_SPRITE_WIDTH:  sprite_width_r  <= cfg_data[SX_W-1:0];
        CFG_SPRITE_HEIGHT: sprite_height_r <= cfg_data[SY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_cur = in_data.start_req ? '0 : col_r;
    row_cur = in_data.start_req ? '0 : row_r;
    fx      = {1'b0, sprite_x_r} + {1'b0, col_cur};
    fy      = {1'b0, sprite_y_r} + {1'b0, row_cur};
    draw    = (col_cur < sprite_width_r) && (row_cur < sprite_height_r) &&
              (32'(fx) < 32'(FRAME_W)) && (32'(fy) < 32'(FRAME_H)) &&
              ((in_data.pixel & ALPHA_MASK) != '0);

    col_inc = {1'b0, col_cur} + FX_W'(1);
    row_inc = {1'b0, row_cur} + FY_W'(1);
    if (col_inc >= {1'b0, sprite_width_r}) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, sprite_height_r}) ? '0 : row_inc[SY_W-1:0];
    end else begin
      col_nxt = col_inc[SX_W-1:0];
      row_nxt = row_cur;
    end
  end

  assign accept = in_push && !q_full;
  assign in_full = q_full;
  // transparent and clipped pixels only move the counters
  assign q_push = accept && draw;
  assign q_data = '{fx: fx, fy: fy, pixel: in_data.pixel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== design/sbca_queue.sv =====
// sbca_queue: small register queue of draw jobs between front and back
// depends on sbca_pkg for the job type
module sbca_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  sbca_pkg::sbca_job_t wr_data,
  input  logic                pop,
  output logic                empty,
  output sbca_pkg::sbca_job_t rd_data
);
  import sbca_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbca_job_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

// ===== design/sbca_back.sv =====
// sbca_back: forms the frame-buffer address and holds the result word
// depends on sbca_pkg; drains sbca_queue
module sbca_back #(
  parameter int FRAME_W = 640
) (
  input  logic                clk,
  input  logic                rst_n,
  output logic                q_pop,
  input  logic                q_empty,
  input  sbca_pkg::sbca_job_t q_data,
  output logic                out_empty,
  input  logic                out_pop,
  output sbca_pkg::sbca_out_t out_data
);
  import sbca_pkg::*;

  localparam int FW_W = $clog2(FRAME_W + 1);
  localparam int AW   = (FY_W + FW_W + 1 > ADDR_W) ? FY_W + FW_W + 1 : ADDR_W;

  logic          out_valid_r;
  sbca_out_t     out_data_r;
  logic [AW-1:0] addr_full;

  // take a new job whenever the result slot is free or being taken
  assign q_pop = !q_empty && (!out_valid_r || out_pop);

  assign addr_full = AW'(q_data.fy) * AW'(FRAME_W) + AW'(q_data.fx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r.write_address <= addr_full[ADDR_W-1:0];
      out_data_r.write_pixel   <= q_data.pixel;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/sprite_blit_clip_alpha.sv =====
// sprite_blit_clip_alpha: top level of the sprite blitter
// depends on sbca_pkg, sbca_front, sbca_queue, sbca_back
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes sprite_x,
//   sprite_y, sprite_width and sprite_height at indexes 0..3; cfg_ready is
//   always high. Write only while no pixel is in flight.
//   Input side is a queue write port: a word (start_req, pixel) is taken on
//   a clock edge with in_push high and in_full low. start_req marks the first
//   pixel of a sprite; pixels follow in row-major order.
//   Output side is a queue read port: while out_empty is low, out_data holds
//   the oldest frame-buffer write (write_address, write_pixel); out_pop takes it.
//   Transparent pixels and pixels outside the sprite or frame give no word.
// Throughput: one pixel per cycle while in_full is low, set by the counter update in
//   the front end and one address multiply-add in the back end.
// Path: a drawn pixel is written into the job queue, then into the registered out_data.
// Stall: when out_pop stays low the result is held, the job queue fills
//   (QUEUE_DEPTH jobs) and in_full rises; dropped pixels pass while it has room.
// Reset (rst_n low, synchronous): configuration registers and counters clear, the job
//   queue and the result slot empty; no clearing pass is needed.
module sprite_blit_clip_alpha #(
  parameter int FRAME_W     = 640,
  parameter int FRAME_H     = 480,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sbca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbca_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           in_push,
  output logic                           in_full,
  input  sbca_pkg::sbca_in_t             in_data,
  output logic                           out_empty,
  input  logic                           out_pop,
  output sbca_pkg::sbca_out_t            out_data
);
  import sbca_pkg::*;

  logic      q_push, q_full, q_pop, q_empty;
  sbca_job_t q_wr_data, q_rd_data;

  sbca_front #(
    .FRAME_W (FRAME_W),
    .FRAME_H (FRAME_H)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_data    (q_wr_data)
  );

  sbca_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  sbca_back #(
    .FRAME_W (FRAME_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_pop     (q_pop),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== design/sbca_checker.sv =====
// sbca_checker: port-level assertions for the sprite blitter, bound to the top
// depends on sbca_pkg and sprite_blit_clip_alpha
module sbca_checker #(
  parameter int FRAME_W = 640,
  parameter int FRAME_H = 480
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input sbca_pkg::sbca_out_t out_data
);
  import sbca_pkg::*;

  localparam longint FRAME_PIX = longint'(FRAME_W) * longint'(FRAME_H);
  localparam bit     ADDR_FITS = (FRAME_PIX <= (64'd1 << ADDR_W));

  // a waiting word that is not taken stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result word changed while stalled");

  // reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending right after reset");

  // reset frees the input side
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full right after reset");

  // every write is opaque and lands inside the frame
  a_word_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_data.write_pixel[15:12] != 4'd0) &&
                    (!ADDR_FITS || (longint'(out_data.write_address) < FRAME_PIX))))
    else $error("bad frame-buffer write");

endmodule

bind sprite_blit_clip_alpha sbca_checker #(
  .FRAME_W (FRAME_W),
  .FRAME_H (FRAME_H)
) u_sbca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

// ===== tb/tb.sv =====
// tb: self-checking testbench for the sprite blitter with alpha key and clipping
// depends on sbca_pkg and sprite_blit_clip_alpha; a scoreboard class predicts
// every frame-buffer write from the accepted pixels and register writes
`timescale 1ns / 1ps

module tb;
  import sbca_pkg::*;

  localparam int FRAME_W       = 640;
  localparam int FRAME_H       = 480;
  localparam int TARGET_PIXELS = 1700;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int FIRST_UNUSED_REG = 4;
  localparam int LAST_UNUSED_REG  = (1 << CFG_IDX_W) - 1;

  // tracks sprite registers and the pixel counters, queues predicted writes
  class frame_write_tracker;
    sbca_out_t        expected_writes[$];
    logic [SX_W-1:0]  pos_x, span_w, col;
    logic [SY_W-1:0]  pos_y, span_h, row;
    int               errors;
    int               checked;

    function new();
      pos_x = '0; pos_y = '0; span_w = '0; span_h = '0;
      col = '0; row = '0;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_SPRITE_X:      pos_x  = data[SX_W-1:0];
        CFG_SPRITE_Y:      pos_y  = data[SY_W-1:0];
        CFG_SPRITE_WIDTH:  span_w = data[SX_W-1:0];
        CFG_SPRITE_HEIGHT: span_h = data[SY_W-1:0];
        default: ;
      endcase
    endfunction

    function void place_pixel(sbca_in_t word);
      int unsigned c, r, fx, fy;
      sbca_out_t   wr;
      if (word.start_req) begin
        col = '0;
        row = '0;
      end
      c  = col;
      r  = row;
      fx = pos_x + c;
      fy = pos_y + r;
      if (c < span_w && r < span_h && fx < FRAME_W && fy < FRAME_H &&
          (word.pixel & ALPHA_MASK) != '0) begin
        wr.write_address = ADDR_W'(fy * FRAME_W + fx);
        wr.write_pixel   = word.pixel;
        expected_writes.push_back(wr);
      end
      c++;
      if (c >= span_w) begin
        c = 0;
        r++;
        if (r >= span_h) r = 0;
      end
      col = c[SX_W-1:0];
      row = r[SY_W-1:0];
    endfunction

    function void check_write(sbca_out_t got);
      sbca_out_t want;
      checked++;
      if (expected_writes.size() == 0) begin
        $error("unexpected write: write_address %0d write_pixel %h",
               got.write_address, got.write_pixel);
        errors++;
        return;
      end
      want = expected_writes.pop_front();
      if (got.write_address !== want.write_address) begin
        $error("write_address: expected %0d, got %0d", want.write_address, got.write_address);
        errors++;
      end
      if (got.write_pixel !== want.write_pixel) begin
        $error("write_pixel: expected %h, got %h", want.write_pixel, got.write_pixel);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_push;
  logic                 in_full;
  sbca_in_t             in_data;
  logic                 out_empty;
  logic                 out_pop;
  sbca_out_t            out_data;

  frame_write_tracker tracker = new();
  int  pixels_sent = 0;
  int  settings = 0;
  int  stalled_cycles = 0;
  bit  calm_phase = 1'b0;
  bit  moved;

  sprite_blit_clip_alpha #(
    .FRAME_W(FRAME_W),
    .FRAME_H(FRAME_H)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // mostly no gap, some short ones, a few long
  function automatic int idle_len();
    int r;
    if (calm_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // inputs change only at rising edges, so the falling edge sees what the
  // next rising edge will take
  always @(negedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        tracker.write_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (in_push && !in_full) begin
        tracker.place_pixel(in_data);
        moved = 1'b1;
      end
      if (!out_empty && out_pop) begin
        tracker.check_write(out_data);
        moved = 1'b1;
      end
      stalled_cycles = moved ? 0 : stalled_cycles + 1;
    end
  end

  initial begin
    while (stalled_cycles < IDLE_LIMIT) @(negedge clk);
    $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver side: bursts of pops with random stalls between them
  initial begin
    out_pop = 1'b0;
    forever begin
      int run;
      int stall;
      run = $urandom_range(1, 12);
      out_pop <= 1'b1;
      repeat (run) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                           input int bits);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    // junk above the register width must be ignored
    cfg_data  <= (CFG_DAT_W'($urandom) << bits) | CFG_DAT_W'(value);
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned x, input int unsigned y,
                           input int unsigned w, input int unsigned h);
    cfg_write(CFG_SPRITE_X, x, SX_W);
    cfg_write(CFG_SPRITE_Y, y, SY_W);
    cfg_write(CFG_SPRITE_WIDTH, w, SX_W);
    cfg_write(CFG_SPRITE_HEIGHT, h, SY_W);
    if ($urandom_range(0, 3) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)), 0, 0);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic push_pixel(input logic start, input logic [PIX_W-1:0] pix);
    sbca_in_t word;
    int       gap;
    word.start_req = start;
    word.pixel     = pix;
    gap = idle_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= word;
    @(negedge clk);
    while (in_full) @(negedge clk);
    @(posedge clk);
    pixels_sent++;
  endtask

  // drain all predicted writes, then give dropped pixels time to leave
  task automatic settle();
    in_push <= 1'b0;
    while (tracker.expected_writes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    logic [3:0] alpha;
    alpha = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
    return {alpha, 12'($urandom)};
  endfunction

  task automatic random_phase();
    int unsigned w, h, x, y, area, npix, nspr;
    logic        start;
    calm_phase = ($urandom_range(0, 5) == 0);
    case ($urandom_range(0, 9))
      0:       w = 0;
      1:       w = $urandom_range(600, 1023);
      default: w = $urandom_range(1, 20);
    endcase
    case ($urandom_range(0, 9))
      0:       h = 0;
      1:       h = $urandom_range(400, 511);
      default: h = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 7))
      0:       x = $urandom_range(FRAME_W, 1023);
      1, 2:    x = FRAME_W - $urandom_range(1, 20);
      3:       x = 0;
      default: x = $urandom_range(0, FRAME_W - 1);
    endcase
    case ($urandom_range(0, 7))
      0:       y = $urandom_range(FRAME_H, 511);
      1, 2:    y = FRAME_H - $urandom_range(1, 12);
      3:       y = 0;
      default: y = $urandom_range(0, FRAME_H - 1);
    endcase
    configure(x, y, w, h);
    nspr = $urandom_range(1, 4);
    for (int s = 0; s < nspr; s++) begin
      area = w * h;
      if (area > 64) area = 64;
      if (area == 0) npix = $urandom_range(1, 6);
      else begin
        case ($urandom_range(0, 9))
          0:       npix = $urandom_range(1, area);
          1:       npix = area + $urandom_range(1, 8);
          default: npix = area;
        endcase
      end
      for (int i = 0; i < npix; i++) begin
        // mostly a clean start flag on the first pixel, rare stray ones later
        start = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
        push_pixel(start, random_pixel());
      end
    end
    settle();
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_push   = 1'b0;
    in_data   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small sprite in the corner: transparency, row step and wrap
    configure(0, 0, 3, 2);
    push_pixel(1'b1, 16'hFFFF);
    push_pixel(1'b0, 16'h0000);
    push_pixel(1'b0, 16'h1000);
    push_pixel(1'b0, 16'h0FFF);
    push_pixel(1'b0, 16'hF000);
    push_pixel(1'b0, 16'h8001);
    push_pixel(1'b0, 16'h7ABC);
    push_pixel(1'b1, 16'h2345);
    settle();
    // last frame pixel, then right and bottom overhang
    configure(FRAME_W - 1, FRAME_H - 1, 2, 2);
    repeat (4) push_pixel(1'b0, 16'hFFFF);
    settle();
    // position far past the frame with the largest sizes
    configure(1023, 511, 1023, 511);
    push_pixel(1'b1, 16'hF0F0);
    push_pixel(1'b0, 16'hFFFF);
    settle();
    // zero width and height
    configure(5, 3, 0, 0);
    push_pixel(1'b1, 16'hFFFF);
    push_pixel(1'b0, 16'hF000);
    settle();
    // x at the frame edge, then y at the frame edge, then zero height
    configure(FRAME_W, 0, 4, 1);
    push_pixel(1'b1, 16'hFFFF);
    push_pixel(1'b0, 16'hFFFF);
    settle();
    configure(0, FRAME_H, 1, 1);
    push_pixel(1'b1, 16'hFFFF);
    settle();
    configure(10, 20, 1, 0);
    push_pixel(1'b1, 16'hFFFF);
    settle();
    // width shrinks in the middle of a sprite
    configure(100, 100, 4, 4);
    push_pixel(1'b1, 16'hFFFF);
    push_pixel(1'b0, 16'h3000);
    push_pixel(1'b0, 16'hC000);
    settle();
    configure(100, 100, 2, 4);
    push_pixel(1'b0, 16'hFFFF);
    push_pixel(1'b0, 16'hFFFF);
    settle();

    while (pixels_sent < TARGET_PIXELS) random_phase();
    calm_phase = 1'b0;
    settle();

    $display("pushed %0d pixels under %0d sprite settings, checked %0d frame-buffer writes",
             pixels_sent, settings, tracker.checked);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
